// ----- hw/rtl/sibs_pkg.sv -----
// ----------------------------------------------------------------------------
// sibs_pkg: shared types and constants of the sorted index search core
// Field widths, operation and register codes, and the table entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sibs_pkg;

  localparam int KEY_W      = 64;
  localparam int KEY_BYTES  = KEY_W / 8;
  localparam int OFFSET_W   = 32;
  localparam int INDEX_W    = 10;
  localparam int KLEN_W     = 4;
  localparam int COUNT_W    = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Operation codes carried in the op field of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  localparam logic [KLEN_W-1:0]  KEY_LENGTH_RESET  = 4'd8;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd0;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  // Outcome of one masked key compare: stored key equal to or above the target.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sibs_in_if.sv -----
// ----------------------------------------------------------------------------
// sibs_in_if: request channel of the sorted index search core
// Valid/ready channel carrying one load or lookup word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sibs_in_if
  import sibs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                op;
  logic [INDEX_W-1:0]  entry_index;
  logic [KEY_W-1:0]    key;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, output op, output entry_index, output key,
                  output offset, input ready);
  modport sink (input valid, input op, input entry_index, input key,
                input offset, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sibs_out_if.sv -----
// ----------------------------------------------------------------------------
// sibs_out_if: response channel of the sorted index search core
// Valid/ready channel carrying one lookup result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sibs_out_if
  import sibs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] result_offset;

  modport source (output valid, output found, output result_offset, input ready);
  modport sink (input valid, input found, input result_offset, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sorted_index_binary_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_index_binary_search_core: binary search over a sorted key table
// The req channel takes load and lookup words. A load writes one key and its
// offset at entry_index when entry_index is below MAX_ENTRIES, and gives no
// response word. A lookup binary-searches the first entry_count entries,
// one table read and one masked compare per probe, and returns one rsp word
// with found and the matched offset (zero when not found). The search uses
// the single memory read port and the one comparator, and ends on a match or
// when no entry is left to probe. req is not ready while a lookup runs, so the
// next word is taken once the result has entered the rsp register; loads are
// taken one per cycle while the core is idle. A finished result waits in the
// rsp register, so a new word is taken while the receiver stalls; a second
// result waits in the core until the register frees. Reset clears control
// state and sets key_length to 8 and entry_count to 0; table contents stay
// undefined until loaded. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_index_binary_search_core
  import sibs_pkg::*;
#(
  parameter int MAX_ENTRIES   = 1024,
  parameter int KEY_BYTES_MAX = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sibs_in_if.sink                    req,
  sibs_out_if.source                 rsp
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_RESP  = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [KLEN_W-1:0]  key_length;
  logic [COUNT_W-1:0] entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= KEY_LENGTH_RESET;
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LENGTH:  key_length  <= cfg_data[KLEN_W-1:0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare mask: one byte lane per enabled key byte, clamped to the maximum.
  logic [KLEN_W-1:0] klen_eff;
  logic [KEY_W-1:0]  mask_now;

  always_comb begin
    klen_eff = (32'(key_length) > 32'(KEY_BYTES_MAX)) ? KLEN_W'(KEY_BYTES_MAX)
                                                      : key_length;
    for (int b = 0; b < KEY_BYTES; b++) begin
      mask_now[b*8 +: 8] = (32'(b) < 32'(klen_eff)) ? 8'hFF : 8'h00;
    end
  end

  // Number of searched entries, clamped to the table depth.
  logic [CW-1:0] n_eff;
  logic [AW-1:0] hi_init;
  logic [AW-1:0] mid_init;

  always_comb begin
    n_eff    = (32'(entry_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                     : CW'(entry_count);
    hi_init  = AW'(n_eff - CW'(1));
    mid_init = hi_init >> 1;
  end

  // Handshake decode.
  logic acc;
  logic acc_load;
  logic acc_lookup;
  logic load_in_range;

  assign req.ready     = (state == S_IDLE);
  assign acc           = req.valid && req.ready;
  assign acc_load      = acc && (req.op == OP_LOAD);
  assign acc_lookup    = acc && (req.op == OP_LOOKUP);
  assign load_in_range = (32'(req.entry_index) < 32'(MAX_ENTRIES));

  // Search state.
  logic [AW-1:0]       lo, hi, mid;
  logic [AW-1:0]       lo_next, hi_next, mid_next;
  logic [KEY_W-1:0]    want;
  logic [KEY_W-1:0]    key_mask;
  logic                found_q;
  logic [OFFSET_W-1:0] result_q;
  logic                finish;
  logic                hit;
  logic [AW:0]         mid_sum;

  entry_t   rd_data;
  entry_t   wr_data;
  cmp_res_t cmp;
  logic     rd_en;
  logic [AW-1:0] rd_addr;

  assign wr_data.key    = req.key;
  assign wr_data.offset = req.offset;

  sibs_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (acc_load && load_in_range),
    .wr_addr (AW'(req.entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sibs_cmp u_cmp (
    .have (rd_data.key),
    .want (want),
    .mask (key_mask),
    .res  (cmp)
  );

  // One probe per cycle: the compare picks the next bounds, and the next
  // middle index goes straight to the read port.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    finish  = 1'b0;
    hit     = 1'b0;
    if (cmp.eq) begin
      finish = 1'b1;
      hit    = 1'b1;
    end else if (cmp.gt) begin
      if (hi == mid) begin
        finish = 1'b1;
      end else begin
        hi_next = mid;
      end
    end else begin
      if (lo == mid) begin
        if (hi == mid) begin
          finish = 1'b1;
        end else begin
          lo_next = hi;
        end
      end else begin
        lo_next = mid;
      end
    end
    mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = mid_sum[AW:1];
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_init;
    if (state == S_PROBE) begin
      rd_en   = !finish;
      rd_addr = mid_next;
    end else if (acc_lookup && (n_eff != '0)) begin
      rd_en = 1'b1;
    end
  end

  // Response register.
  logic                out_valid;
  logic                out_found;
  logic [OFFSET_W-1:0] out_offset;
  logic                out_load;

  assign out_load = (state == S_RESP) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_lookup) begin
          state_next = (n_eff != '0) ? S_PROBE : S_RESP;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_lookup) begin
      lo       <= '0;
      hi       <= hi_init;
      mid      <= mid_init;
      want     <= req.key & mask_now;
      key_mask <= mask_now;
      found_q  <= 1'b0;
      result_q <= '0;
    end else if (state == S_PROBE) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (hit) begin
        found_q  <= 1'b1;
        result_q <= rd_data.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found  <= found_q;
      out_offset <= result_q;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.result_offset = out_offset;

`ifndef NO_ASSERTIONS
  // The search window never inverts and the probe stays inside it.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo <= mid) && (mid <= hi))
    else $error("search window out of order");

  // A lookup on an empty table goes straight to the response as not found.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (acc_lookup && (n_eff == '0)) |=> (state == S_RESP) && !found_q)
    else $error("empty-table lookup did not short-cut");

  // A miss always carries a zero offset.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.result_offset == '0))
    else $error("miss with nonzero offset");

  // A response word never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !out_load)
    else $error("response register overwritten");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sibs_table.sv -----
// ----------------------------------------------------------------------------
// sibs_table: key and offset table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sibs_table
  import sibs_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sibs_cmp.sv -----
// ----------------------------------------------------------------------------
// sibs_cmp: masked key comparator
// Compares a stored key with the target key over the enabled bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sibs_cmp
  import sibs_pkg::*;
(
  input  wire logic [KEY_W-1:0] have,
  input  wire logic [KEY_W-1:0] want,
  input  wire logic [KEY_W-1:0] mask,
  output cmp_res_t              res
);

  logic [KEY_W-1:0] have_m;
  logic [KEY_W-1:0] want_m;

  assign have_m = have & mask;
  assign want_m = want & mask;
  assign res.eq = (have_m == want_m);
  assign res.gt = (have_m > want_m);

endmodule

`default_nettype wire
